@@ design/ghr_pkg.sv @@
// ghr_pkg: shared types, constants and helper for the grip hold-and-ramp controller
// no dependencies; imported by every module of the block

package ghr_pkg;

  // pressure sample width
  localparam int PRESSURE_BITS = 12;

  // divide-by-50 through a reciprocal multiply, one correction step
  localparam int DIVISOR      = 50;
  localparam int RECIP        = 1310;            // floor(2^16 / 50), under-estimates
  localparam int RECIP_BITS   = 11;
  localparam int RECIP_SHIFT  = 16;
  localparam int PROD_W       = PRESSURE_BITS + RECIP_BITS;
  localparam int QUOT_W       = PROD_W - RECIP_SHIFT;
  localparam int SUM_W        = PRESSURE_BITS + 4;

  localparam int ANGLE_W      = 8;
  localparam int TIME_W       = 32;
  localparam int CFG_INDEX_W  = 2;
  localparam int CFG_DATA_W   = 32;

  // configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] CFG_PRESSURE_THRESHOLD = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_ANGLE_OPEN         = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_ANGLE_CLOSED       = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_HOLD_TIME_US       = 2'd3;

  typedef enum logic [2:0] {
    MODE_IDLE_OPEN   = 3'd0,
    MODE_HOLD_OPEN   = 3'd1,
    MODE_CLOSING     = 3'd2,
    MODE_CLOSED      = 3'd3,
    MODE_IDLE_CLOSED = 3'd4,
    MODE_HOLD_CLOSE  = 3'd5,
    MODE_OPENING     = 3'd6,
    MODE_OPEN        = 3'd7
  } mode_t;

  typedef struct packed {
    logic [PRESSURE_BITS-1:0] pressure;
    logic [TIME_W-1:0]        now_us;
  } in_item_t;

  typedef struct packed {
    logic [ANGLE_W-1:0] angle_cmd;
    logic               servo_update;
    logic [2:0]         hand_mode;
  } out_item_t;

  typedef struct packed {
    logic [PRESSURE_BITS-1:0] pressure_threshold;
    logic [ANGLE_W-1:0]       angle_open;
    logic [ANGLE_W-1:0]       angle_closed;
    logic [TIME_W-1:0]        hold_time_us;
  } cfg_t;

  // p / 50: reciprocal estimate is exact or one short, fixed by one compare
  function automatic logic [QUOT_W-1:0] div_by_divisor(input logic [PRESSURE_BITS-1:0] p);
    logic [PROD_W-1:0]        prod;
    logic [QUOT_W-1:0]        q0;
    logic [PRESSURE_BITS-1:0] rem;
    prod = PROD_W'(p) * PROD_W'(RECIP);
    q0   = prod[RECIP_SHIFT +: QUOT_W];
    rem  = p - PRESSURE_BITS'(PRESSURE_BITS'(q0) * PRESSURE_BITS'(DIVISOR));
    if (rem >= PRESSURE_BITS'(DIVISOR)) begin
      q0 = q0 + QUOT_W'(1);
    end
    return q0;
  endfunction

endpackage

@@ design/ghr_cfg_regs.sv @@
// ghr_cfg_regs: configuration register file of the grip controller
// depends on ghr_pkg for the register indexes and the cfg_t bundle

module ghr_cfg_regs import ghr_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   wr_en,
  input  logic [CFG_INDEX_W-1:0] wr_index,
  input  logic [CFG_DATA_W-1:0]  wr_data,
  output cfg_t                   cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.pressure_threshold <= PRESSURE_BITS'(500);
      cfg.angle_open         <= ANGLE_W'(0);
      cfg.angle_closed       <= ANGLE_W'(180);
      cfg.hold_time_us       <= TIME_W'(300000);
    end else if (wr_en) begin
      case (wr_index)
        CFG_PRESSURE_THRESHOLD: cfg.pressure_threshold <= wr_data[PRESSURE_BITS-1:0];
        CFG_ANGLE_OPEN:         cfg.angle_open         <= wr_data[ANGLE_W-1:0];
        CFG_ANGLE_CLOSED:       cfg.angle_closed       <= wr_data[ANGLE_W-1:0];
        CFG_HOLD_TIME_US:       cfg.hold_time_us       <= wr_data[TIME_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

@@ design/ghr_core.sv @@
// ghr_core: hand state machine, servo angle ramp and hold timer
// depends on ghr_pkg for mode_t, item structs and the divide helper

module ghr_core import ghr_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      step,
  input  in_item_t  item,
  input  cfg_t      cfg,
  output out_item_t result
);

  mode_t              mode;
  mode_t              mode_next;
  logic [ANGLE_W-1:0] angle;
  logic [ANGLE_W-1:0] angle_next;
  logic [TIME_W-1:0]  hold_start;
  logic               hold_load;
  logic               update;
  logic               above;
  logic               below;
  logic               expired;
  logic [TIME_W-1:0]  elapsed;
  logic [QUOT_W-1:0]  quot;
  logic [SUM_W-1:0]   sum;

  assign above   = item.pressure > cfg.pressure_threshold;
  assign below   = item.pressure < cfg.pressure_threshold;
  // wraps modulo 2^32 with the timestamp
  assign elapsed = item.now_us - hold_start;
  assign expired = elapsed > cfg.hold_time_us;
  assign quot    = div_by_divisor(item.pressure);
  assign sum     = SUM_W'(angle) + SUM_W'(quot) + SUM_W'(1);

  always_comb begin
    mode_next  = mode;
    angle_next = angle;
    hold_load  = 1'b0;
    update     = 1'b0;
    case (mode)
      MODE_IDLE_OPEN: begin
        if (above) begin
          hold_load = 1'b1;
          mode_next = MODE_HOLD_OPEN;
        end
      end
      MODE_HOLD_OPEN: begin
        if (!above) begin
          mode_next = MODE_IDLE_OPEN;
        end else if (expired) begin
          mode_next = MODE_CLOSING;
        end
      end
      MODE_CLOSING: begin
        if (above && (angle < cfg.angle_closed)) begin
          angle_next = (sum > SUM_W'(cfg.angle_closed)) ? cfg.angle_closed
                                                        : sum[ANGLE_W-1:0];
          update     = 1'b1;
        end else begin
          mode_next = MODE_CLOSED;
        end
      end
      MODE_CLOSED: begin
        if (below) begin
          mode_next = MODE_IDLE_CLOSED;
        end
      end
      MODE_IDLE_CLOSED: begin
        if (above) begin
          hold_load = 1'b1;
          mode_next = MODE_HOLD_CLOSE;
        end
      end
      MODE_HOLD_CLOSE: begin
        if (!above) begin
          mode_next = MODE_IDLE_CLOSED;
        end else if (expired) begin
          mode_next = MODE_OPENING;
        end
      end
      MODE_OPENING: begin
        angle_next = cfg.angle_open;
        update     = 1'b1;
        mode_next  = MODE_OPEN;
      end
      MODE_OPEN: begin
        if (below) begin
          mode_next = MODE_IDLE_OPEN;
        end
      end
      default: begin
        mode_next = MODE_IDLE_OPEN;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode  <= MODE_IDLE_OPEN;
      angle <= '0;
    end else if (step) begin
      mode  <= mode_next;
      angle <= angle_next;
    end
  end

  // always written on entry to a hold state before it is read
  always_ff @(posedge clk) begin
    if (step && hold_load) begin
      hold_start <= item.now_us;
    end
  end

  assign result.angle_cmd    = angle_next;
  assign result.servo_update = update;
  assign result.hand_mode    = mode_next;

endmodule

@@ design/grip_hold_ramp_controller_unit.sv @@
// grip_hold_ramp_controller_unit: top level of the grip hold-and-ramp controller
// depends on ghr_pkg, ghr_cfg_regs and ghr_core
//
// usage
//   in channel  (in_valid/in_ready/in_data): one pressure sample plus its
//     microsecond timestamp per transfer
//   out channel (out_valid/out_ready/out_data): exactly one result per input
//     transfer, in order: servo angle, update flag and hand mode after the step
//   cfg channel (cfg_valid/cfg_ready/cfg_index/cfg_data): register writes,
//     always ready, only to be used while the block is idle
// path: a sample taken into the input register is evaluated by the state
//   machine and lands in the result register as it moves on, when the
//   result register is free or being emptied
// throughput: one item per cycle while out_ready is high; the core state
//   steps once per item, and the input and result registers move together
// reset (rst, synchronous): hand is idle-open with angle zero, registers take
//   their default values, both pipeline stages are emptied
// stall: while out_ready is low the result is held; one more item can wait in
//   the input register, after which in_ready drops

module grip_hold_ramp_controller_unit import ghr_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  in_item_t               in_data,
  output logic                   out_valid,
  input  logic                   out_ready,
  output out_item_t              out_data,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  cfg_t      cfg;
  in_item_t  item_q;
  logic      item_valid;
  logic      advance;
  out_item_t result;

  // config writes never stall
  assign cfg_ready = 1'b1;

  ghr_cfg_regs u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  // item in the input register moves on when the result register is free
  // or being emptied in this cycle
  assign advance  = item_valid && (!out_valid || out_ready);
  assign in_ready = !item_valid || advance;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (in_ready) begin
      item_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_q <= in_data;
    end
  end

  // state machine, state changes only when the item moves on
  ghr_core u_core (
    .clk    (clk),
    .rst    (rst),
    .step   (advance),
    .item   (item_q),
    .cfg    (cfg),
    .result (result)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data <= result;
    end
  end

`ifndef ASSERT_OFF
  // a new angle is only commanded while ramping or on the step into open
  a_update_mode: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.servo_update |->
      (out_data.hand_mode == MODE_CLOSING) || (out_data.hand_mode == MODE_OPEN))
    else $error("servo update outside closing or opening step");

  // reopening always commands the configured open angle
  a_open_angle: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.servo_update && (out_data.hand_mode == MODE_OPEN) |->
      out_data.angle_cmd == cfg.angle_open)
    else $error("reopen angle differs from angle_open");

  // input back-pressure only when both stages are full and the output stalls
  a_ready_backpressure: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> item_valid && out_valid && !out_ready)
    else $error("input stalled without a full pipeline");

  // an item that moves on always produces a result in the next cycle
  a_advance_result: assert property (@(posedge clk) disable iff (rst)
    advance |=> out_valid)
    else $error("result lost after item advanced");
`endif

endmodule

@@ tb/sv/tb_grip_hold_ramp_controller_unit.sv @@
// tb_grip_hold_ramp_controller_unit: self-checking testbench for the grip hold-and-ramp controller
// depends on ghr_pkg and grip_hold_ramp_controller_unit; predicts every result in-line
// covers directed corner cases, output back-pressure and randomised grip gestures

module tb_grip_hold_ramp_controller_unit;
  import ghr_pkg::*;

  // generous bound on the whole run, many times the slowest legal run
  localparam int RUN_LIMIT = 200000;
  // each closing step adds pressure / PRESS_STEP_DIV + 1 degrees
  localparam int PRESS_STEP_DIV = 50;
  localparam logic [PRESSURE_BITS-1:0] PRESSURE_TOP = '1;

  // clock, reset and block inputs, all known from time zero
  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   in_valid = 1'b0;
  logic                   in_ready;
  in_item_t               in_data = '0;
  logic                   out_valid;
  logic                   out_ready = 1'b0;
  out_item_t              out_data;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;

  // predictor copy of the register file, reset values
  logic [PRESSURE_BITS-1:0] threshold_cfg = 12'd500;
  logic [ANGLE_W-1:0]       angle_open_cfg = 8'd0;
  logic [ANGLE_W-1:0]       angle_closed_cfg = 8'd180;
  logic [TIME_W-1:0]        hold_time_cfg = 32'd300000;

  // predictor copy of the hand state; hold start is always written before it is read
  mode_t                    grip_mode = MODE_IDLE_OPEN;
  logic [ANGLE_W-1:0]       grip_angle = '0;
  logic [TIME_W-1:0]        grip_hold_start = '0;

  // results still owed by the block, oldest first
  out_item_t                pending_grip_results[$];

  // shared run state
  logic [TIME_W-1:0]        clock_us = '0;      // running sensor timestamp
  bit                       idle_on = 1'b1;     // random gaps and stalls on both sides
  int                       ready_hold_cycles = 0;
  int                       samples_sent = 0;
  int                       mismatch_count = 0;
  int                       cycle_count = 0;

  grip_hold_ramp_controller_unit uut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // watchdog: a hung handshake ends the run as a failure
  always @(posedge clk) begin
    cycle_count = cycle_count + 1;
    if (cycle_count >= RUN_LIMIT) begin
      $display("%0t: timeout after %0d cycles, %0d results outstanding", $time, cycle_count,
               pending_grip_results.size());
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // prediction: one step of the grip state machine per accepted sample
  // ---------------------------------------------------------------------------
  function automatic out_item_t next_grip_result(input in_item_t sample);
    logic [PRESSURE_BITS-1:0] p;
    logic [TIME_W-1:0]        elapsed;
    int unsigned              ramped;
    out_item_t                res;
    p       = sample.pressure;
    elapsed = sample.now_us - grip_hold_start;   // wraps modulo 2^32
    res     = '0;
    case (grip_mode)
      MODE_IDLE_OPEN: begin
        if (p > threshold_cfg) begin
          grip_hold_start = sample.now_us;
          grip_mode       = MODE_HOLD_OPEN;
        end
      end
      MODE_HOLD_OPEN: begin
        if (p <= threshold_cfg) grip_mode = MODE_IDLE_OPEN;
        else if (elapsed > hold_time_cfg) grip_mode = MODE_CLOSING;
      end
      MODE_CLOSING: begin
        // ramp while squeezing, saturating at the closed limit
        if (p > threshold_cfg && grip_angle < angle_closed_cfg) begin
          ramped = 32'(grip_angle) + 32'(p) / PRESS_STEP_DIV + 1;
          grip_angle = (ramped > 32'(angle_closed_cfg)) ? angle_closed_cfg
                                                        : ANGLE_W'(ramped);
          res.servo_update = 1'b1;
        end else begin
          grip_mode = MODE_CLOSED;
        end
      end
      MODE_CLOSED: begin
        if (p < threshold_cfg) grip_mode = MODE_IDLE_CLOSED;
      end
      MODE_IDLE_CLOSED: begin
        if (p > threshold_cfg) begin
          grip_hold_start = sample.now_us;
          grip_mode       = MODE_HOLD_CLOSE;
        end
      end
      MODE_HOLD_CLOSE: begin
        if (p <= threshold_cfg) grip_mode = MODE_IDLE_CLOSED;
        else if (elapsed > hold_time_cfg) grip_mode = MODE_OPENING;
      end
      MODE_OPENING: begin
        grip_angle       = angle_open_cfg;
        res.servo_update = 1'b1;
        grip_mode        = MODE_OPEN;
      end
      default: begin
        if (p < threshold_cfg) grip_mode = MODE_IDLE_OPEN;
      end
    endcase
    res.angle_cmd = grip_angle;
    res.hand_mode = grip_mode;
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // result side: random stalls, plus one long hold-off on request
  // ---------------------------------------------------------------------------
  initial begin : result_receiver
    int stall;
    wait (rst === 1'b0);
    forever begin
      if (ready_hold_cycles > 0) begin
        stall = ready_hold_cycles;
        ready_hold_cycles = 0;
      end else begin
        stall = idle_on ? $urandom_range(0, 8) : 0;
      end
      if (stall > 0) begin
        @(negedge clk);
        out_ready <= 1'b0;
        repeat (stall - 1) @(negedge clk);
      end
      @(negedge clk);
      out_ready <= 1'b1;
      // hold ready until a result transfer completes
      do @(posedge clk); while (out_valid !== 1'b1);
    end
  end

  // compare every result transfer against the oldest outstanding prediction
  always @(posedge clk) begin : result_checker
    out_item_t want;
    if (!rst && out_valid === 1'b1 && out_ready) begin
      if (pending_grip_results.size() == 0) begin
        $display("%0t: unexpected result, expected none, got angle %0d update %0b mode %0d",
                 $time, out_data.angle_cmd, out_data.servo_update, out_data.hand_mode);
        mismatch_count = mismatch_count + 1;
      end else begin
        want = pending_grip_results.pop_front();
        if (out_data.angle_cmd !== want.angle_cmd) begin
          $display("%0t: angle_cmd expected %0d, got %0d", $time, want.angle_cmd,
                   out_data.angle_cmd);
          mismatch_count = mismatch_count + 1;
        end
        if (out_data.servo_update !== want.servo_update) begin
          $display("%0t: servo_update expected %0b, got %0b", $time, want.servo_update,
                   out_data.servo_update);
          mismatch_count = mismatch_count + 1;
        end
        if (out_data.hand_mode !== want.hand_mode) begin
          $display("%0t: hand_mode expected %0d, got %0d", $time, want.hand_mode,
                   out_data.hand_mode);
          mismatch_count = mismatch_count + 1;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // sample side
  // ---------------------------------------------------------------------------

  // offer one sample; valid stays high across back-to-back transfers
  task automatic send_sample(input logic [PRESSURE_BITS-1:0] p, input logic [TIME_W-1:0] stamp);
    in_item_t sample;
    int       gap;
    sample.pressure = p;
    sample.now_us   = stamp;
    gap = idle_on ? $urandom_range(0, 8) : 0;
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= sample;
    do @(posedge clk); while (!in_ready);
    // transfer taken at this edge: predict its result now
    pending_grip_results.push_back(next_grip_result(sample));
    samples_sent = samples_sent + 1;
  endtask

  // stop offering and let every owed result come back
  task automatic drain_pipeline();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_grip_results.size() != 0) @(posedge clk);
    // two-stage pipeline, then a spare wait before the next phase
    repeat (4) @(posedge clk);
  endtask

  // one register write; only called with the block drained
  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_PRESSURE_THRESHOLD: threshold_cfg = val[PRESSURE_BITS-1:0];
      CFG_ANGLE_OPEN:         angle_open_cfg = val[ANGLE_W-1:0];
      CFG_ANGLE_CLOSED:       angle_closed_cfg = val[ANGLE_W-1:0];
      CFG_HOLD_TIME_US:       hold_time_cfg = val;
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // pressure that counts as a contraction, or the top code if none can
  function automatic logic [PRESSURE_BITS-1:0] above_threshold();
    if (threshold_cfg == PRESSURE_TOP) return PRESSURE_TOP;
    return PRESSURE_BITS'($urandom_range(32'(threshold_cfg) + 1, 32'(PRESSURE_TOP)));
  endfunction

  // resting pressure, sometimes sitting exactly on the threshold
  function automatic logic [PRESSURE_BITS-1:0] below_threshold();
    if (threshold_cfg == '0 || $urandom_range(0, 4) == 0) return threshold_cfg;
    return PRESSURE_BITS'($urandom_range(0, 32'(threshold_cfg) - 1));
  endfunction

  // advance the sensor clock (steps scaled to a short hold time, else random), jumping near the wrap
  function automatic logic [TIME_W-1:0] next_timestamp();
    if ($urandom_range(0, 39) == 0) begin
      clock_us = 32'hFFFF_FF00 + $urandom_range(0, 255);
    end else if (hold_time_cfg < 32'h0100_0000) begin
      clock_us = clock_us + $urandom_range(0, hold_time_cfg / 2 + 2);
    end else begin
      clock_us = clock_us + $urandom;
    end
    return clock_us;
  endfunction

  // a squeeze of random length followed by a rest
  task automatic run_gesture();
    int presses;
    int rests;
    presses = $urandom_range(1, 12);
    rests   = $urandom_range(1, 4);
    repeat (presses) send_sample(above_threshold(), next_timestamp());
    repeat (rests) send_sample(below_threshold(), next_timestamp());
  endtask

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // full close and abandoned reopen with the reset register values
  task automatic test_default_registers();
    send_sample(12'd500, 32'd10);         // on the threshold: no contraction
    send_sample(12'd501, 32'd100);        // hold timer starts
    send_sample(12'd4095, 32'd300100);    // exactly the hold time: keep waiting
    send_sample(12'd4095, 32'd300101);    // hold time passed: start closing
    repeat (3) send_sample(12'd4095, 32'd300102);   // 82, 164, then clipped to 180
    send_sample(12'd4095, 32'd300103);    // at the limit: closed
    send_sample(12'd0, 32'd300104);       // relax while closed
    send_sample(12'd4095, 32'd300105);    // start of a reopen hold
    send_sample(12'd0, 32'd300106);       // released too early
  endtask

  // reopen hold that straddles the timestamp wrap
  task automatic test_timestamp_wrap();
    drain_pipeline();
    write_reg(CFG_HOLD_TIME_US, 32'h0000_001F);
    write_reg(CFG_ANGLE_OPEN, 32'd180);
    send_sample(12'd4095, 32'hFFFF_FFF0);
    send_sample(12'd4095, 32'h0000_000F); // elapsed equals the hold time
    send_sample(12'd4095, 32'h0000_0010); // elapsed one more: opening
    send_sample(12'd0, 32'h0000_0011);    // opening ignores pressure, angle to open
    send_sample(12'd0, 32'h0000_0012);    // back to idle-open
  endtask

  // closed limit lowered beneath the current angle mid-close
  task automatic test_angle_above_limit();
    drain_pipeline();
    write_reg(CFG_HOLD_TIME_US, 32'd0);
    send_sample(12'd4095, 32'd100);
    send_sample(12'd4095, 32'd101);       // closing with the angle still at 180
    drain_pipeline();
    write_reg(CFG_ANGLE_CLOSED, 32'd100);
    send_sample(12'd4095, 32'd102);       // closed, angle left alone
    send_sample(12'd0, 32'd103);
  endtask

  // threshold at both ends of its range
  task automatic test_threshold_extremes();
    drain_pipeline();
    write_reg(CFG_PRESSURE_THRESHOLD, 32'd0);
    send_sample(12'd0, 32'd200);          // zero is not above zero
    send_sample(12'd1, 32'd201);
    send_sample(12'd1, 32'd201);          // no time passed: still holding
    send_sample(12'd1, 32'd202);
    send_sample(12'd0, 32'd203);          // opening step
    drain_pipeline();
    write_reg(CFG_PRESSURE_THRESHOLD, 32'd4095);
    send_sample(12'd4095, 32'd204);       // top code is not below the top threshold
    send_sample(12'd4094, 32'd205);
  endtask

  // long result stall while samples keep coming, so the input must back off
  task automatic test_output_backpressure();
    drain_pipeline();
    write_reg(CFG_PRESSURE_THRESHOLD, 32'd500);
    write_reg(CFG_ANGLE_CLOSED, 32'd180);
    write_reg(CFG_ANGLE_OPEN, 32'd0);
    write_reg(CFG_HOLD_TIME_US, 32'd2000);
    idle_on = 1'b0;
    ready_hold_cycles = 60;
    repeat (3) run_gesture();
    idle_on = 1'b1;
  endtask

  // phases of random registers, each followed by a run of gestures and noise
  task automatic test_random_gestures();
    int phase;
    int phase_start;
    for (phase = 0; phase < 14; phase++) begin
      drain_pipeline();
      // first two phases pin every register to an extreme
      write_reg(CFG_PRESSURE_THRESHOLD,
                (phase == 0) ? 32'd0 : (phase == 1) ? 32'd4095 : $urandom_range(50, 3500));
      write_reg(CFG_ANGLE_OPEN,
                (phase == 0) ? 32'd0 : (phase == 1) ? 32'd180 : $urandom_range(0, 180));
      write_reg(CFG_ANGLE_CLOSED,
                (phase == 0) ? 32'd180 : (phase == 1) ? 32'd0 : $urandom_range(0, 180));
      write_reg(CFG_HOLD_TIME_US,
                (phase == 0) ? 32'd0 : (phase == 1) ? 32'hFFFF_FFFF :
                (phase % 5 == 2) ? $urandom : $urandom_range(0, 5000));
      // some phases run flat out with no gaps or stalls
      idle_on = ($urandom_range(0, 3) != 0);
      phase_start = samples_sent;
      while (samples_sent - phase_start < 46) begin
        if ($urandom_range(0, 9) == 0) begin
          send_sample(PRESSURE_BITS'($urandom), $urandom);   // raw noise
        end else begin
          run_gesture();
        end
      end
    end
    idle_on = 1'b1;
  endtask

  // ---------------------------------------------------------------------------
  // sequence
  // ---------------------------------------------------------------------------
  initial begin
    // reset held from time zero, released on a falling edge
    repeat (3) @(negedge clk);
    rst <= 1'b0;

    test_default_registers();
    test_timestamp_wrap();
    test_angle_above_limit();
    test_threshold_extremes();
    test_output_backpressure();
    test_random_gestures();

    // everything owed back, then a quiet spell to catch stray results
    drain_pipeline();
    repeat (10) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
design/ghr_pkg.sv
design/ghr_cfg_regs.sv
design/ghr_core.sv
design/grip_hold_ramp_controller_unit.sv
tb/sv/tb_grip_hold_ramp_controller_unit.sv
